### rtl/scrq_pkg.sv
// Shared types, constants and helper functions of the sequenced command reorder queue.
// Depends on nothing; every other RTL file of the block refers to it by scoped names.
`default_nettype none

package scrq_pkg;

  // Default sizes of the queue.
  localparam int QUEUE_DEPTH_DEF  = 256;
  localparam int PAYLOAD_BITS_DEF = 64;

  // Fixed field widths of the request and response.
  localparam int SEQ_W     = 32;
  localparam int PEER_W    = 32;
  localparam int PAYLOAD_W = 64;
  localparam int OPCODE_W  = 2;
  localparam int STATUS_W  = 3;
  localparam int QCOUNT_W  = 9;
  localparam int LIMIT_W   = 7;

  // A tick releases at most this many commands; the reset value of the limit register.
  localparam logic [LIMIT_W-1:0] TICK_CAP      = LIMIT_W'(64);
  localparam logic [LIMIT_W-1:0] TICK_LIMIT_RST = LIMIT_W'(16);

  // Fan-in of one node of the match reduction tree, as a power of two.
  localparam int TREE_FANIN_LOG2 = 4;
  localparam int TREE_FANIN      = 1 << TREE_FANIN_LOG2;

  typedef logic [SEQ_W-1:0]     seq_t;
  typedef logic [PEER_W-1:0]    peer_t;
  typedef logic [PAYLOAD_W-1:0] payload_t;
  typedef logic [QCOUNT_W-1:0]  qcount_t;
  typedef logic [LIMIT_W-1:0]   limit_t;

  // Request opcodes.
  localparam logic [OPCODE_W-1:0] OP_RECEIVE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_TICK    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RESET   = 2'd2;

  // Response kinds.
  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Status codes of a response.
  localparam logic [STATUS_W-1:0] STATUS_STORED       = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_STORED_EVICT = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_STALE        = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_DUPLICATE    = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_WRONG_PEER   = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_SELF_EVICT   = 3'd5;
  localparam logic [STATUS_W-1:0] STATUS_CLEARED      = 3'd6;

  // Configuration register indexes (byte address bit 2).
  localparam logic REG_CONTROLLER_PEER = 1'b0;
  localparam logic REG_MAX_PER_TICK    = 1'b1;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    peer_t               from_peer;
    seq_t                seq;
    payload_t            command_payload;
  } in_req_t;

  typedef struct packed {
    logic                kind;
    logic [STATUS_W-1:0] status;
    seq_t                out_seq;
    payload_t            out_payload;
    logic                last_of_run;
    qcount_t             queued_count;
    seq_t                last_applied_seq;
  } out_rsp_t;

  // Operation broadcast to every cell of the sorted chain.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_INSERT_EVICT,
    CELL_POP,
    CELL_CLEAR
  } cell_op_e;

  // Control sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_APPLY,
    ST_CLEAR,
    ST_POP
  } state_e;

  // Number of nodes at a given level of the reduction tree over width leaves.
  function automatic int tree_level_width(input int width, input int level);
    int w;
    w = width;
    for (int l = 0; l < level; l++) begin
      w = (w + TREE_FANIN - 1) >> TREE_FANIN_LOG2;
    end
    return w;
  endfunction

  // Register levels needed to reduce width leaves to one bit, at least one.
  function automatic int tree_levels(input int width);
    int w;
    int n;
    w = (width + TREE_FANIN - 1) >> TREE_FANIN_LOG2;
    n = 1;
    while (w > 1) begin
      w = (w + TREE_FANIN - 1) >> TREE_FANIN_LOG2;
      n = n + 1;
    end
    return n;
  endfunction

  // Release limit of one tick: zero acts as one, anything above the cap acts as the cap.
  function automatic limit_t tick_limit(input limit_t max_per_tick);
    limit_t lim;
    lim = max_per_tick;
    if (max_per_tick == '0) begin
      lim = LIMIT_W'(1);
    end else if (max_per_tick > TICK_CAP) begin
      lim = TICK_CAP;
    end
    return lim;
  endfunction

endpackage

`default_nettype wire

### rtl/scrq_cell.sv
// One cell of the sorted command chain: holds a sequence number, a payload and a valid bit.
// Depends on scrq_pkg for the cell operation type.
`default_nettype none

module scrq_cell #(
  parameter int PAYLOAD_BITS = scrq_pkg::PAYLOAD_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire scrq_pkg::cell_op_e      op_i,
  input  wire scrq_pkg::seq_t          new_seq_i,
  input  wire logic [PAYLOAD_BITS-1:0] new_payload_i,
  input  wire scrq_pkg::seq_t          left_seq_i,
  input  wire logic [PAYLOAD_BITS-1:0] left_payload_i,
  input  wire logic                    left_valid_i,
  input  wire logic                    left_lt_i,
  input  wire scrq_pkg::seq_t          right_seq_i,
  input  wire logic [PAYLOAD_BITS-1:0] right_payload_i,
  input  wire logic                    right_valid_i,
  input  wire logic                    right_lt_i,
  output logic                         valid_o,
  output scrq_pkg::seq_t               seq_o,
  output logic [PAYLOAD_BITS-1:0]      payload_o,
  output logic                         lt_o,
  output logic                         eq_o
);

  logic                    valid_q, valid_d;
  scrq_pkg::seq_t          seq_q, seq_d;
  logic [PAYLOAD_BITS-1:0] payload_q, payload_d;

  // The held number lies below the broadcast one, or equals it.
  assign lt_o = valid_q && (seq_q < new_seq_i);
  assign eq_o = valid_q && (seq_q == new_seq_i);

  always_comb begin
    valid_d   = valid_q;
    seq_d     = seq_q;
    payload_d = payload_q;
    case (op_i)
      scrq_pkg::CELL_INSERT: begin
        // Cells above the insertion point move up by one.
        valid_d = valid_q | left_valid_i;
        if (!lt_o) begin
          if (left_lt_i) begin
            seq_d     = new_seq_i;
            payload_d = new_payload_i;
          end else begin
            seq_d     = left_seq_i;
            payload_d = left_payload_i;
          end
        end
      end
      scrq_pkg::CELL_INSERT_EVICT: begin
        // Full chain: cells below the insertion point move down, the head falls out.
        if (right_lt_i) begin
          seq_d     = right_seq_i;
          payload_d = right_payload_i;
        end else if (lt_o) begin
          seq_d     = new_seq_i;
          payload_d = new_payload_i;
        end
      end
      scrq_pkg::CELL_POP: begin
        valid_d   = right_valid_i;
        seq_d     = right_seq_i;
        payload_d = right_payload_i;
      end
      scrq_pkg::CELL_CLEAR: begin
        valid_d = 1'b0;
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q     <= seq_d;
    payload_q <= payload_d;
  end

  assign valid_o   = valid_q;
  assign seq_o     = seq_q;
  assign payload_o = payload_q;

endmodule

`default_nettype wire

### rtl/scrq_or_tree.sv
// Registered OR reduction over the per-cell match flags, one register level per fan-in step.
// Depends on scrq_pkg for the fan-in and the level arithmetic.
`default_nettype none

module scrq_or_tree #(
  parameter int WIDTH = scrq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic [WIDTH-1:0] bits_i,
  output logic                  hit_o
);

  localparam int LEVELS = scrq_pkg::tree_levels(WIDTH);

  logic [WIDTH-1:0] lvl [LEVELS+1];

  assign lvl[0] = bits_i;

  for (genvar l = 1; l <= LEVELS; l++) begin : g_level
    localparam int PREV = scrq_pkg::tree_level_width(WIDTH, l - 1);
    localparam int CUR  = scrq_pkg::tree_level_width(WIDTH, l);

    logic [WIDTH-1:0] node_d;

    always_comb begin
      node_d = '0;
      for (int n = 0; n < CUR; n++) begin
        for (int k = 0; k < scrq_pkg::TREE_FANIN; k++) begin
          if (n * scrq_pkg::TREE_FANIN + k < PREV) begin
            node_d[n] = node_d[n] | lvl[l-1][n * scrq_pkg::TREE_FANIN + k];
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      lvl[l] <= node_d;
    end
  end

  assign hit_o = lvl[LEVELS][0];

endmodule

`default_nettype wire

### rtl/sequenced_command_reorder_queue.sv
// Sequenced command reorder queue: a sorted chain of command cells with its control sequencer.
// Depends on scrq_pkg, scrq_cell and scrq_or_tree.
//
// The queue keeps commands from the configured controller peer in ascending order of their
// sequence numbers, in a chain of QUEUE_DEPTH identical cells. Every cell compares its number
// with the broadcast request and moves its contents one place up or down the chain together
// with its neighbors, so an insertion, an eviction of the smallest number, or the release of
// the head moves the whole chain at once, whatever the depth. Duplicate detection ORs the
// match flags of all cells through a registered tree with a fan-in of 16. A receive
// request waits in the search state while the match flags pass all register levels of
// the tree (2 for the default depth of 256) and then produces one status response. A tick
// releases N commands, one per cycle while the output register can take them, where N is
// the smaller of the queue fill and the release limit; a tick on an empty queue produces
// nothing. A session reset empties the queue and produces one status response. New
// requests are taken only when the previous one has finished its work; a response waits in an
// output register while the next request is already accepted. There is no clearing pass after
// reset: the valid bits of the cells clear at once. Configuration registers are at byte
// address 0 (controller peer) and 4 (release limit) and must only be written while idle.
`default_nettype none

module sequenced_command_reorder_queue #(
  parameter int QUEUE_DEPTH  = scrq_pkg::QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_BITS = scrq_pkg::PAYLOAD_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Request channel.
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire scrq_pkg::in_req_t  in_req_i,
  // Response channel.
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output scrq_pkg::out_rsp_t      out_rsp_o,
  // Configuration port.
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TREE_LEVELS = scrq_pkg::tree_levels(QUEUE_DEPTH);
  localparam int WAIT_W      = (TREE_LEVELS > 1) ? $clog2(TREE_LEVELS) : 1;
  localparam logic [WAIT_W-1:0] WAIT_LAST = WAIT_W'(TREE_LEVELS - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_DEPTH);

  // ---------------------------------------------------------------------------------------
  // Configuration registers. Writes complete in the APB access phase; pready is tied high.
  // ---------------------------------------------------------------------------------------
  scrq_pkg::peer_t  peer_q;
  scrq_pkg::limit_t max_q;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peer_q <= '0;
      max_q  <= scrq_pkg::TICK_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (paddr[2])
        scrq_pkg::REG_CONTROLLER_PEER: peer_q <= pwdata;
        scrq_pkg::REG_MAX_PER_TICK:    max_q  <= pwdata[scrq_pkg::LIMIT_W-1:0];
        default:                       peer_q <= peer_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      scrq_pkg::REG_CONTROLLER_PEER: prdata = peer_q;
      scrq_pkg::REG_MAX_PER_TICK:    prdata = 32'(max_q);
      default:                       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Sequencer state and the request being worked on.
  // ---------------------------------------------------------------------------------------
  scrq_pkg::state_e   state_q, state_d;
  scrq_pkg::in_req_t  req_q;
  logic [WAIT_W-1:0]  wait_q;
  scrq_pkg::limit_t   rel_q, rel_d;
  logic [CNT_W-1:0]   count_q, count_d;
  scrq_pkg::seq_t     applied_q, applied_d;
  logic               out_valid_q;
  scrq_pkg::out_rsp_t out_rsp_q, rsp_d;
  logic               out_load;
  logic               out_free;
  logic               in_accept;
  scrq_pkg::cell_op_e cell_op;

  // ---------------------------------------------------------------------------------------
  // The sorted chain. Cell 0 holds the smallest number. Cell 0 sees a virtual left neighbor
  // that is valid and below every number, so an insertion in front lands in cell 0; the top
  // cell sees an empty right neighbor, so a release shifts an empty slot in at the top.
  // ---------------------------------------------------------------------------------------
  logic [QUEUE_DEPTH-1:0]  cell_valid;
  logic [QUEUE_DEPTH-1:0]  cell_lt;
  logic [QUEUE_DEPTH-1:0]  cell_eq;
  scrq_pkg::seq_t          cell_seq [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_pl  [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0] new_pl;
  logic                    dup_hit;

  assign new_pl = req_q.command_payload[PAYLOAD_BITS-1:0];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    scrq_pkg::seq_t          left_seq, right_seq;
    logic [PAYLOAD_BITS-1:0] left_pl, right_pl;
    logic                    left_valid, left_lt, right_valid, right_lt;

    if (i == 0) begin : g_head
      assign left_seq   = req_q.seq;
      assign left_pl    = new_pl;
      assign left_valid = 1'b1;
      assign left_lt    = 1'b1;
    end else begin : g_left
      assign left_seq   = cell_seq[i-1];
      assign left_pl    = cell_pl[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_lt    = cell_lt[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_seq   = '0;
      assign right_pl    = '0;
      assign right_valid = 1'b0;
      assign right_lt    = 1'b0;
    end else begin : g_right
      assign right_seq   = cell_seq[i+1];
      assign right_pl    = cell_pl[i+1];
      assign right_valid = cell_valid[i+1];
      assign right_lt    = cell_lt[i+1];
    end

    scrq_cell #(
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .op_i            (cell_op),
      .new_seq_i       (req_q.seq),
      .new_payload_i   (new_pl),
      .left_seq_i      (left_seq),
      .left_payload_i  (left_pl),
      .left_valid_i    (left_valid),
      .left_lt_i       (left_lt),
      .right_seq_i     (right_seq),
      .right_payload_i (right_pl),
      .right_valid_i   (right_valid),
      .right_lt_i      (right_lt),
      .valid_o         (cell_valid[i]),
      .seq_o           (cell_seq[i]),
      .payload_o       (cell_pl[i]),
      .lt_o            (cell_lt[i]),
      .eq_o            (cell_eq[i])
    );
  end

  // Any cell holding the received number marks the request as a duplicate. The answer
  // is ready once the match flags have passed through the register levels of the tree.
  scrq_or_tree #(
    .WIDTH (QUEUE_DEPTH)
  ) u_dup_tree (
    .clk_i  (clk_i),
    .bits_i (cell_eq),
    .hit_o  (dup_hit)
  );

  // ---------------------------------------------------------------------------------------
  // Decisions of the sequencer.
  // ---------------------------------------------------------------------------------------
  logic             peer_ok;
  logic             stale;
  logic             full;
  logic             pop_last;
  scrq_pkg::limit_t tick_lim;
  logic [CNT_W-1:0] count_dec;

  assign peer_ok   = (req_q.from_peer == peer_q);
  assign stale     = (req_q.seq <= applied_q);
  assign full      = (count_q >= FULL_CNT);
  assign tick_lim  = scrq_pkg::tick_limit(max_q);
  assign count_dec = count_q - CNT_W'(1);
  // The release that empties the queue or reaches the limit ends the tick.
  assign pop_last  = ((rel_q + scrq_pkg::LIMIT_W'(1)) == tick_lim) || (count_q == CNT_W'(1));

  // The output register takes a new response when it is empty or being drained.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == scrq_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      scrq_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (in_req_i.opcode)
            scrq_pkg::OP_RECEIVE: state_d = scrq_pkg::ST_SEARCH;
            scrq_pkg::OP_TICK: begin
              state_d = (count_q != '0) ? scrq_pkg::ST_POP : scrq_pkg::ST_IDLE;
            end
            scrq_pkg::OP_RESET:   state_d = scrq_pkg::ST_CLEAR;
            default:              state_d = scrq_pkg::ST_IDLE;
          endcase
        end
      end
      scrq_pkg::ST_SEARCH: begin
        if (wait_q == WAIT_LAST) begin
          state_d = scrq_pkg::ST_APPLY;
        end
      end
      scrq_pkg::ST_APPLY, scrq_pkg::ST_CLEAR: begin
        if (out_free) begin
          state_d = scrq_pkg::ST_IDLE;
        end
      end
      scrq_pkg::ST_POP: begin
        if (out_free && pop_last) begin
          state_d = scrq_pkg::ST_IDLE;
        end
      end
      default: state_d = scrq_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: chain operation, response and bookkeeping updates.
  always_comb begin
    cell_op   = scrq_pkg::CELL_HOLD;
    out_load  = 1'b0;
    count_d   = count_q;
    applied_d = applied_q;
    rel_d     = rel_q;

    rsp_d.kind             = scrq_pkg::KIND_STATUS;
    rsp_d.status           = scrq_pkg::STATUS_STORED;
    rsp_d.out_seq          = req_q.seq;
    rsp_d.out_payload      = '0;
    rsp_d.last_of_run      = 1'b1;
    rsp_d.queued_count     = scrq_pkg::qcount_t'(count_q);
    rsp_d.last_applied_seq = applied_q;

    unique case (state_q)
      scrq_pkg::ST_IDLE: begin
        rel_d = '0;
      end
      scrq_pkg::ST_APPLY: begin
        if (out_free) begin
          out_load = 1'b1;
          if (!peer_ok) begin
            rsp_d.status = scrq_pkg::STATUS_WRONG_PEER;
          end else if (stale) begin
            rsp_d.status = scrq_pkg::STATUS_STALE;
          end else if (dup_hit) begin
            rsp_d.status = scrq_pkg::STATUS_DUPLICATE;
          end else if (full && !cell_lt[0]) begin
            // The new number is the smallest of a full queue, so it is the one dropped.
            rsp_d.status = scrq_pkg::STATUS_SELF_EVICT;
          end else if (full) begin
            cell_op      = scrq_pkg::CELL_INSERT_EVICT;
            rsp_d.status = scrq_pkg::STATUS_STORED_EVICT;
          end else begin
            cell_op            = scrq_pkg::CELL_INSERT;
            count_d            = count_q + CNT_W'(1);
            rsp_d.status       = scrq_pkg::STATUS_STORED;
            rsp_d.queued_count = scrq_pkg::qcount_t'(count_d);
          end
        end
      end
      scrq_pkg::ST_CLEAR: begin
        if (out_free) begin
          out_load               = 1'b1;
          cell_op                = scrq_pkg::CELL_CLEAR;
          count_d                = '0;
          applied_d              = '0;
          rsp_d.status           = scrq_pkg::STATUS_CLEARED;
          rsp_d.out_seq          = '0;
          rsp_d.queued_count     = '0;
          rsp_d.last_applied_seq = '0;
        end
      end
      scrq_pkg::ST_POP: begin
        if (out_free) begin
          out_load               = 1'b1;
          cell_op                = scrq_pkg::CELL_POP;
          count_d                = count_dec;
          applied_d              = cell_seq[0];
          rel_d                  = rel_q + scrq_pkg::LIMIT_W'(1);
          rsp_d.kind             = scrq_pkg::KIND_RELEASE;
          rsp_d.status           = scrq_pkg::STATUS_STORED;
          rsp_d.out_seq          = cell_seq[0];
          rsp_d.out_payload      = scrq_pkg::payload_t'(cell_pl[0]);
          rsp_d.last_of_run      = pop_last;
          rsp_d.queued_count     = scrq_pkg::qcount_t'(count_dec);
          rsp_d.last_applied_seq = cell_seq[0];
        end
      end
      default: begin
        cell_op = scrq_pkg::CELL_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scrq_pkg::ST_IDLE;
      wait_q      <= '0;
      rel_q       <= '0;
      count_q     <= '0;
      applied_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rel_q     <= rel_d;
      count_q   <= count_d;
      applied_q <= applied_d;
      if (in_accept) begin
        wait_q <= '0;
      end else if (state_q == scrq_pkg::ST_SEARCH) begin
        wait_q <= wait_q + WAIT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_req_i;
    end
    if (out_load) begin
      out_rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef SYNTHESIS
  // The number of valid cells always matches the fill count.
  a_fill_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == 32'(count_q))
    else $error("cell valid bits disagree with the fill count");

  // A response appears only from a state that produces one.
  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == scrq_pkg::ST_APPLY ||
                            $past(state_q) == scrq_pkg::ST_CLEAR ||
                            $past(state_q) == scrq_pkg::ST_POP))
    else $error("response loaded outside of apply, clear or release");

  // The last applied number moves only on a release or a session reset.
  a_applied_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(applied_q) |-> ($past(state_q) == scrq_pkg::ST_POP ||
                             $past(state_q) == scrq_pkg::ST_CLEAR))
    else $error("last applied number changed outside of a release or reset");

  // A release lowers the queue fill by exactly one.
  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == scrq_pkg::ST_POP && out_free) |=> (count_q == $past(count_dec)))
    else $error("release did not take one command from the queue");
`endif

endmodule

`default_nettype wire
